@@ rtl/pfcc_pkg.sv @@
`timescale 1ns / 1ps

package pfcc_pkg;

  localparam logic [15:0] THRESHOLD_RESET = 16'd3000;
  localparam logic [7:0]  ON_CODE_DEF     = 8'd1;
  localparam logic [7:0]  OFF_CODE_DEF    = 8'd0;
  localparam logic [7:0]  SAVE_CODE_DEF   = 8'd2;
  localparam logic [31:0] CNT_MAX         = 32'hFFFF_FFFF;

  // reported power mode codes
  localparam logic [1:0] PM_ON     = 2'd0;
  localparam logic [1:0] PM_OFF    = 2'd1;
  localparam logic [1:0] PM_SAVING = 2'd2;

  typedef enum logic [3:0] {
    MODE_START  = 4'b0001,
    MODE_ON     = 4'b0010,
    MODE_OFF    = 4'b0100,
    MODE_SAVING = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [15:0] voltage_mv;
    logic [63:0] handshake_value;
  } in_t;

  typedef struct packed {
    logic        irq;
    logic        handshake_write;
    logic [7:0]  handshake_write_value;
    logic [1:0]  power_mode;
    logic [31:0] interrupts_raised;
    logic [31:0] lost_interrupts;
  } out_t;

  typedef struct packed {
    mode_t       mode;
    logic [63:0] prev_hs;
    logic        armed;
    logic        restore_pending;
    logic [31:0] irq_total;
    logic [31:0] lost_total;
  } st_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == CNT_MAX) ? c : c + 32'd1;
  endfunction

endpackage

@@ rtl/power_fail_checkpoint_controller.sv @@
`timescale 1ns / 1ps
// The input register holds an accepted item; the result register takes its result
// (out_*) when free. Throughput: one item per cycle unless out_stall backs up;
// the two-stage pipeline's state update is a single compare-and-count step.
// Reset (rst_n low, synchronous): pipeline emptied, mode back to start, counters,
// handshake tracking and flags cleared, threshold back to 3000 mV.

module power_fail_checkpoint_controller #(
  parameter logic [7:0] ON_CODE   = pfcc_pkg::ON_CODE_DEF,
  parameter logic [7:0] OFF_CODE  = pfcc_pkg::OFF_CODE_DEF,
  parameter logic [7:0] SAVE_CODE = pfcc_pkg::SAVE_CODE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  pfcc_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output pfcc_pkg::out_t out_item
);

  logic           s1_vld_r;
  pfcc_pkg::in_t  s1_item_r;
  logic           out_vld_r;
  pfcc_pkg::out_t out_item_r;
  pfcc_pkg::st_t  st_r;
  pfcc_pkg::st_t  st_nxt;
  pfcc_pkg::out_t result;
  logic [15:0]    threshold_r;
  logic           out_free;
  logic           adv;

  assign out_free  = !out_vld_r || !out_stall;
  assign adv       = s1_vld_r && out_free;
  assign in_stall  = s1_vld_r && !out_free;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  pfcc_core #(
    .ON_CODE  (ON_CODE),
    .OFF_CODE (OFF_CODE),
    .SAVE_CODE(SAVE_CODE)
  ) u_core (
    .st       (st_r),
    .item     (s1_item_r),
    .threshold(threshold_r),
    .st_nxt   (st_nxt),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= pfcc_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en && cfg_wr_data != '0) begin
      threshold_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode            <= pfcc_pkg::MODE_START;
      st_r.prev_hs         <= '0;
      st_r.armed           <= 1'b0;
      st_r.restore_pending <= 1'b0;
      st_r.irq_total       <= '0;
      st_r.lost_total      <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  a_armed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.armed |=> st_r.armed)
    else $error("handshake disarmed after arming");

  a_irq_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $past(st_r.irq_total) <= st_r.irq_total)
    else $error("interrupt count decreased");

  a_lost_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $past(st_r.lost_total) <= st_r.lost_total)
    else $error("lost count decreased");

  a_wr_val_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_item_r.handshake_write |-> out_item_r.handshake_write_value == '0)
    else $error("write value set without write");

endmodule

@@ rtl/pfcc_core.sv @@
`timescale 1ns / 1ps

module pfcc_core #(
  parameter logic [7:0] ON_CODE   = pfcc_pkg::ON_CODE_DEF,
  parameter logic [7:0] OFF_CODE  = pfcc_pkg::OFF_CODE_DEF,
  parameter logic [7:0] SAVE_CODE = pfcc_pkg::SAVE_CODE_DEF
) (
  input  pfcc_pkg::st_t  st,
  input  pfcc_pkg::in_t  item,
  input  logic [15:0]    threshold,
  output pfcc_pkg::st_t  st_nxt,
  output pfcc_pkg::out_t result
);

  logic       good;
  logic       irq;
  logic       wr;
  logic [7:0] wr_val;

  assign good = item.voltage_mv > threshold;

  always_comb begin
    st_nxt = st;
    irq    = 1'b0;
    wr     = 1'b0;
    wr_val = '0;

    case (st.mode)
      pfcc_pkg::MODE_START: begin
        st_nxt.mode = good ? pfcc_pkg::MODE_ON : pfcc_pkg::MODE_OFF;
      end
      default: begin
        if (good) begin
          if (st.mode == pfcc_pkg::MODE_OFF) begin
            st_nxt.restore_pending = 1'b1;
          end
          if (st.mode == pfcc_pkg::MODE_SAVING) begin
            st_nxt.lost_total = pfcc_pkg::sat_inc(st.lost_total);
          end
          st_nxt.mode = pfcc_pkg::MODE_ON;
        end else if (st.mode == pfcc_pkg::MODE_ON) begin
          irq         = 1'b1;
          st_nxt.mode = pfcc_pkg::MODE_SAVING;
        end
      end
    endcase

    if (st.armed) begin
      if (item.handshake_value == {56'd0, SAVE_CODE}) begin
        st_nxt.mode = pfcc_pkg::MODE_OFF;
        wr          = 1'b1;
        wr_val      = OFF_CODE;
      end
      if (st_nxt.restore_pending) begin
        st_nxt.restore_pending = 1'b0;
        wr                     = 1'b1;
        wr_val                 = ON_CODE;
      end
    end else begin
      if (st.prev_hs != '0 && item.handshake_value == '0) begin
        st_nxt.armed = 1'b1;
      end
      st_nxt.prev_hs = item.handshake_value;
    end

    if (irq) begin
      st_nxt.irq_total = pfcc_pkg::sat_inc(st.irq_total);
    end
  end

  always_comb begin
    result.irq                   = irq;
    result.handshake_write       = wr;
    result.handshake_write_value = wr_val;
    result.interrupts_raised     = st_nxt.irq_total;
    result.lost_interrupts       = st_nxt.lost_total;
    case (st_nxt.mode)
      pfcc_pkg::MODE_OFF:    result.power_mode = pfcc_pkg::PM_OFF;
      pfcc_pkg::MODE_SAVING: result.power_mode = pfcc_pkg::PM_SAVING;
      default:               result.power_mode = pfcc_pkg::PM_ON;
    endcase
  end

endmodule

@@ tb/pfcc_tick_checker.sv @@
`timescale 1ns / 1ps

module pfcc_tick_checker
  import pfcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_item,
  output int          fail_count,
  output int          pending_results
);

  logic [15:0] thr_mv;
  logic [1:0]  pwr_mode;
  logic        started;
  logic [63:0] last_hs;
  logic        armed;
  logic        restore_due;
  logic [31:0] irq_cnt;
  logic [31:0] lost_cnt;

  out_t expected_q[$];
  out_t want;
  out_t pred;

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  task automatic report_error(string what, logic [63:0] got, logic [63:0] exp_val);
    if (fail_count < 200) begin
      $display("ERROR @%0t: %s got %0h, expected %0h", $realtime, what, got, exp_val);
    end
    fail_count++;
  endtask

  function automatic out_t next_tick(in_t it);
    out_t r;
    logic good;
    r = '0;
    good = it.voltage_mv > thr_mv;
    if (!started) begin
      started = 1'b1;
      pwr_mode = good ? PM_ON : PM_OFF;
    end else if (good) begin
      if (pwr_mode == PM_OFF) begin
        restore_due = 1'b1;
      end else if (pwr_mode == PM_SAVING && lost_cnt != CNT_MAX) begin
        lost_cnt = lost_cnt + 32'd1;
      end
      pwr_mode = PM_ON;
    end else if (pwr_mode == PM_ON) begin
      r.irq = 1'b1;
      pwr_mode = PM_SAVING;
    end

    if (armed) begin
      if (it.handshake_value == 64'(SAVE_CODE_DEF)) begin
        pwr_mode = PM_OFF;
        r.handshake_write = 1'b1;
        r.handshake_write_value = OFF_CODE_DEF;
      end
      // restore goes after the save, so ON code wins
      if (restore_due) begin
        restore_due = 1'b0;
        r.handshake_write = 1'b1;
        r.handshake_write_value = ON_CODE_DEF;
      end
    end else begin
      if (last_hs != 64'd0 && it.handshake_value == 64'd0) begin
        armed = 1'b1;
      end
      last_hs = it.handshake_value;
    end

    if (r.irq && irq_cnt != CNT_MAX) begin
      irq_cnt = irq_cnt + 32'd1;
    end
    r.power_mode = pwr_mode;
    r.interrupts_raised = irq_cnt;
    r.lost_interrupts = lost_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thr_mv = THRESHOLD_RESET;
      pwr_mode = PM_ON;
      started = 1'b0;
      last_hs = '0;
      armed = 1'b0;
      restore_due = 1'b0;
      irq_cnt = '0;
      lost_cnt = '0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_error("unexpected item, power_mode", 64'(out_item.power_mode), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_item.irq !== want.irq)
            report_error("irq", 64'(out_item.irq), 64'(want.irq));
          if (out_item.handshake_write !== want.handshake_write)
            report_error("handshake_write", 64'(out_item.handshake_write),
                         64'(want.handshake_write));
          if (out_item.handshake_write_value !== want.handshake_write_value)
            report_error("handshake_write_value", 64'(out_item.handshake_write_value),
                         64'(want.handshake_write_value));
          if (out_item.power_mode !== want.power_mode)
            report_error("power_mode", 64'(out_item.power_mode), 64'(want.power_mode));
          if (out_item.interrupts_raised !== want.interrupts_raised)
            report_error("interrupts_raised", 64'(out_item.interrupts_raised),
                         64'(want.interrupts_raised));
          if (out_item.lost_interrupts !== want.lost_interrupts)
            report_error("lost_interrupts", 64'(out_item.lost_interrupts),
                         64'(want.lost_interrupts));
        end
      end
      if (cfg_wr_en && cfg_wr_data != 16'd0) begin
        thr_mv = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        pred = next_tick(in_item);
        expected_q.insert(expected_q.size(), pred);
      end
    end
    pending_results <= expected_q.size();
  end

endmodule

@@ tb/power_fail_checkpoint_controller_test.sv @@
`timescale 1ns / 1ps

module power_fail_checkpoint_controller_test;
  import pfcc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_item;

  int          fail_count;
  int          pending_results;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  bit          supply_good = 1'b1;
  logic [15:0] cur_thr = THRESHOLD_RESET;
  logic [15:0] phase_thr [PHASES];
  in_t         directed [$];

  always #5 clk = ~clk;

  power_fail_checkpoint_controller i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  pfcc_tick_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stall before each item
  initial begin
    int n;
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_tick(in_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic drain_and_write(logic [15:0] thr);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (thr != 16'd0) cur_thr = thr;
  endtask

  function automatic in_t random_tick();
    in_t it;
    int pick;
    if ($urandom_range(0, 3) == 0) supply_good = ~supply_good;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      it.voltage_mv = 16'($urandom);
    end else if (supply_good && cur_thr != 16'hFFFF) begin
      if (pick < 8) it.voltage_mv = cur_thr + 16'd1;
      else if (pick < 11) it.voltage_mv = 16'hFFFF;
      else it.voltage_mv = 16'($urandom_range(32'(cur_thr) + 1, 65535));
    end else begin
      if (pick < 8) it.voltage_mv = cur_thr;
      else if (pick < 11) it.voltage_mv = 16'd0;
      else it.voltage_mv = 16'($urandom_range(0, 32'(cur_thr)));
    end
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: it.handshake_value = 64'(SAVE_CODE_DEF);
      4, 5:       it.handshake_value = '0;
      6:          it.handshake_value = 64'(SAVE_CODE_DEF) | (64'd1 << $urandom_range(8, 63));
      7:          it.handshake_value = 64'(ON_CODE_DEF);
      default:    it.handshake_value = {$urandom, $urandom};
    endcase
    return it;
  endfunction

  initial begin
    directed = '{
      '{16'd2000,  64'd0},
      '{16'd5000,  64'd2},
      '{16'd5000,  64'd5},
      '{16'd3000,  64'd0},
      '{16'd65535, 64'd2},
      '{16'd0,     64'd0},
      '{16'd4000,  64'hFFFF_FFFF_FFFF_FFFF},
      '{16'd100,   64'd2},
      '{16'd3001,  64'h1_0000_0002},
      '{16'd3001,  64'd2},
      '{16'd0,     64'd0},
      '{16'd3001,  64'd0},
      '{16'd2999,  64'd0},
      '{16'd0,     64'hFFFF_FFFF_FFFF_FFFF},
      '{16'd3001,  64'h8000_0000_0000_0002}
    };
    phase_thr = '{16'd1, 16'hFFFF, 16'd0, 16'd2, 16'hFFFE, 16'd0, 16'd3000,
                  16'd0, 16'd1, 16'd0, 16'hFFFF};
    phase_thr[5] = 16'($urandom_range(1, 65535));
    phase_thr[9] = 16'($urandom_range(100, 60000));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first tick, arming, save/restore corner cases at reset threshold
    foreach (directed[k]) send_tick(directed[k]);
    // zero threshold write must be ignored
    drain_and_write(16'd0);
    send_tick('{16'd3000, 64'd0});
    send_tick('{16'd3001, 64'd2});

    for (int p = 0; p < PHASES; p++) begin
      drain_and_write(phase_thr[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_tick(random_tick());
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pfcc_pkg.sv
rtl/pfcc_core.sv
rtl/power_fail_checkpoint_controller.sv
tb/pfcc_tick_checker.sv
tb/power_fail_checkpoint_controller_test.sv
